// ===== hw/rtl/rdgq_pkg.sv =====
package rdgq_pkg;

    localparam int unsigned TickSumW = 24;
    localparam int unsigned TimeSumW = 32;
    localparam int unsigned StepW    = 16;
    localparam int unsigned ElapsedW = 20;
    localparam int unsigned CfgW     = 16;
    localparam int unsigned ProdW    = 48;

    localparam logic [19:0] UsPerSecond = 20'd1000000;

    localparam logic [CfgW-1:0] TickThresholdReset = 16'd5;
    localparam logic [CfgW-1:0] FastRateReset      = 16'd150;

    typedef enum logic [1:0] {
        ACT_STEP   = 2'd0,
        ACT_DIAL   = 2'd1,
        ACT_INPUT  = 2'd2,
        ACT_ACK    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EV_LEFT       = 3'd0,
        EV_LEFT_FAST  = 3'd1,
        EV_RIGHT      = 3'd2,
        EV_RIGHT_FAST = 3'd3,
        EV_PUSH       = 3'd4,
        EV_REWARD     = 3'd5,
        EV_FLUSH      = 3'd6
    } t_event;

    typedef enum logic {
        CFG_TICK_THRESHOLD = 1'b0,
        CFG_FAST_RATE      = 1'b1
    } t_cfg_index;

    localparam logic [2:0] ChanReward = 3'd0;
    localparam logic [2:0] ChanFlush  = 3'd7;

    typedef struct packed {
        t_action                    action;
        logic signed [StepW-1:0]    step_ticks;
        logic [ElapsedW-1:0]        elapsed_us;
        logic                       input_level;
        logic [2:0]                 input_channel;
    } t_item;

    typedef struct packed {
        logic                       turn;
        logic                       left;
        logic [TickSumW-1:0]        mag;
        logic [TimeSumW-1:0]        time_us;
        t_event                     code;
    } t_mid;

endpackage

// ===== hw/rtl/rotary_dial_gesture_qualifier.sv =====
// Front-panel event qualifier.
// Input channel: i_valid / o_stall carry one item (action, step ticks, elapsed
// time, input level and channel). An item is taken when i_valid is high and
// o_stall is low.
// Output channel: o_valid / i_stall carry one event code. Items that cause no
// event (steps not above the threshold, acknowledges, unused levels) produce nothing.
// Pipeline: an item passes the input register, the sum update register and the
// rate classify register before its event appears on o_valid.
// Throughput: one item per cycle while the pipe is not stalled; the running sums
// close their loop in the update stage, and the rate test multipliers sit in the last stage.
// Stall: while the output holds an event and i_stall is high, the whole pipe
// holds and o_stall is raised the same cycle; an empty output never holds the pipe.
// Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes the tick and fast
// rate thresholds; write only while the block is idle.
// Reset: synchronous, active low; sums, pending turn and dial level clear,
// thresholds return to 5 and 150, the pipe empties.
module rotary_dial_gesture_qualifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_action,
    input  logic signed [15:0]                  i_step_ticks,
    input  logic [19:0]                         i_elapsed_us,
    input  logic                                i_input_level,
    input  logic [2:0]                          i_input_channel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_event_code,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    logic                                       en;
    logic                                       r_in_valid;
    rdgq_pkg::t_item                            r_in;
    logic [rdgq_pkg::CfgW-1:0]                  r_tick_threshold;
    logic [rdgq_pkg::CfgW-1:0]                  r_fast_rate;
    logic                                       mid_valid;
    rdgq_pkg::t_mid                             mid;
    logic                                       out_valid;
    rdgq_pkg::t_event                           out_code;

    assign en      = !(out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_threshold <= rdgq_pkg::TickThresholdReset;
            r_fast_rate      <= rdgq_pkg::FastRateReset;
        end else if (i_cfg_we) begin
            unique case (rdgq_pkg::t_cfg_index'(i_cfg_index))
                rdgq_pkg::CFG_TICK_THRESHOLD: r_tick_threshold <= i_cfg_data;
                rdgq_pkg::CFG_FAST_RATE:      r_fast_rate      <= i_cfg_data;
                default:                      r_fast_rate      <= r_fast_rate;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_in.action        <= rdgq_pkg::t_action'(i_action);
            r_in.step_ticks    <= i_step_ticks;
            r_in.elapsed_us    <= i_elapsed_us;
            r_in.input_level   <= i_input_level;
            r_in.input_channel <= i_input_channel;
        end
    end

    rdgq_update u_update (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_item_valid     (r_in_valid),
        .i_item           (r_in),
        .i_tick_threshold (r_tick_threshold),
        .o_mid_valid      (mid_valid),
        .o_mid            (mid)
    );

    rdgq_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_mid_valid  (mid_valid),
        .i_mid        (mid),
        .i_fast_rate  (r_fast_rate),
        .o_valid      (out_valid),
        .o_event_code (out_code)
    );

    assign o_valid      = out_valid;
    assign o_event_code = out_code;

endmodule

// ===== hw/rtl/rdgq_update.sv =====
module rdgq_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_item_valid,
    input  rdgq_pkg::t_item                     i_item,
    input  logic [rdgq_pkg::CfgW-1:0]           i_tick_threshold,
    output logic                                o_mid_valid,
    output rdgq_pkg::t_mid                      o_mid
);

    logic signed [rdgq_pkg::StepW-1:0]          r_prev_step;
    logic signed [rdgq_pkg::TickSumW-1:0]       r_tick_sum;
    logic [rdgq_pkg::TimeSumW-1:0]              r_time_sum;
    logic                                       r_pending;
    logic                                       r_dial_pressed;
    logic                                       r_mid_valid;
    rdgq_pkg::t_mid                             r_mid;

    logic signed [rdgq_pkg::StepW-1:0]          n_prev_step;
    logic signed [rdgq_pkg::TickSumW-1:0]       n_tick_sum;
    logic [rdgq_pkg::TimeSumW-1:0]              n_time_sum;
    logic                                       n_pending;
    logic                                       n_dial_pressed;
    logic                                       n_mid_valid;
    rdgq_pkg::t_mid                             n_mid;

    logic                                       reversal;
    logic signed [rdgq_pkg::TickSumW:0]         sum_wide;
    logic signed [rdgq_pkg::TickSumW-1:0]       sum_sat;
    logic [rdgq_pkg::TimeSumW:0]                time_wide;
    logic [rdgq_pkg::TimeSumW-1:0]              time_sat;
    logic signed [rdgq_pkg::TickSumW-1:0]       acc_sum;
    logic [rdgq_pkg::TimeSumW-1:0]              acc_time;
    logic [rdgq_pkg::TickSumW-1:0]              mag;
    logic                                       qualify;

    always_comb begin
        reversal = (r_prev_step[rdgq_pkg::StepW-1] && !i_item.step_ticks[rdgq_pkg::StepW-1]
                    && (i_item.step_ticks != '0))
                || (!r_prev_step[rdgq_pkg::StepW-1] && (r_prev_step != '0)
                    && i_item.step_ticks[rdgq_pkg::StepW-1]);

        sum_wide = {r_tick_sum[rdgq_pkg::TickSumW-1], r_tick_sum}
                 + {{(rdgq_pkg::TickSumW + 1 - rdgq_pkg::StepW)
                     {i_item.step_ticks[rdgq_pkg::StepW-1]}}, i_item.step_ticks};
        if (sum_wide[rdgq_pkg::TickSumW] != sum_wide[rdgq_pkg::TickSumW-1]) begin
            sum_sat = sum_wide[rdgq_pkg::TickSumW]
                    ? {1'b1, {(rdgq_pkg::TickSumW-1){1'b0}}}
                    : {1'b0, {(rdgq_pkg::TickSumW-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[rdgq_pkg::TickSumW-1:0];
        end

        time_wide = {1'b0, r_time_sum}
                  + {{(rdgq_pkg::TimeSumW + 1 - rdgq_pkg::ElapsedW){1'b0}}, i_item.elapsed_us};
        time_sat  = time_wide[rdgq_pkg::TimeSumW] ? '1 : time_wide[rdgq_pkg::TimeSumW-1:0];

        if (reversal) begin
            acc_sum  = {{(rdgq_pkg::TickSumW - rdgq_pkg::StepW)
                         {i_item.step_ticks[rdgq_pkg::StepW-1]}}, i_item.step_ticks};
            acc_time = {{(rdgq_pkg::TimeSumW - rdgq_pkg::ElapsedW){1'b0}}, i_item.elapsed_us};
        end else begin
            acc_sum  = sum_sat;
            acc_time = time_sat;
        end

        mag     = acc_sum[rdgq_pkg::TickSumW-1] ? -acc_sum : acc_sum;
        qualify = mag > {{(rdgq_pkg::TickSumW - rdgq_pkg::CfgW){1'b0}}, i_tick_threshold};

        n_prev_step    = r_prev_step;
        n_tick_sum     = r_tick_sum;
        n_time_sum     = r_time_sum;
        n_pending      = r_pending;
        n_dial_pressed = r_dial_pressed;
        n_mid_valid    = 1'b0;
        n_mid.turn     = 1'b0;
        n_mid.left     = 1'b0;
        n_mid.mag      = mag;
        n_mid.time_us  = acc_time;
        n_mid.code     = rdgq_pkg::EV_PUSH;

        if (i_item_valid) begin
            unique case (i_item.action)
                rdgq_pkg::ACT_STEP: begin
                    n_prev_step = i_item.step_ticks;
                    if (qualify) begin
                        n_tick_sum  = '0;
                        n_time_sum  = '0;
                        n_pending   = 1'b1;
                        n_mid_valid = !r_pending;
                        n_mid.turn  = 1'b1;
                        n_mid.left  = !acc_sum[rdgq_pkg::TickSumW-1] && (acc_sum != '0);
                    end else begin
                        n_tick_sum = acc_sum;
                        n_time_sum = acc_time;
                    end
                end
                rdgq_pkg::ACT_DIAL: begin
                    n_tick_sum     = '0;
                    n_time_sum     = '0;
                    n_dial_pressed = i_item.input_level;
                    n_mid_valid    = !i_item.input_level && r_dial_pressed;
                    n_mid.code     = rdgq_pkg::EV_PUSH;
                end
                rdgq_pkg::ACT_INPUT: begin
                    if (i_item.input_level && i_item.input_channel == rdgq_pkg::ChanReward) begin
                        n_mid_valid = 1'b1;
                        n_mid.code  = rdgq_pkg::EV_REWARD;
                    end else if (i_item.input_level
                                 && i_item.input_channel == rdgq_pkg::ChanFlush) begin
                        n_mid_valid = 1'b1;
                        n_mid.code  = rdgq_pkg::EV_FLUSH;
                    end
                end
                rdgq_pkg::ACT_ACK: begin
                    n_pending = 1'b0;
                end
                default: begin
                    n_pending = r_pending;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_step    <= '0;
            r_tick_sum     <= '0;
            r_time_sum     <= '0;
            r_pending      <= 1'b0;
            r_dial_pressed <= 1'b0;
            r_mid_valid    <= 1'b0;
        end else if (i_en) begin
            r_prev_step    <= n_prev_step;
            r_tick_sum     <= n_tick_sum;
            r_time_sum     <= n_time_sum;
            r_pending      <= n_pending;
            r_dial_pressed <= n_dial_pressed;
            r_mid_valid    <= n_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule

// ===== hw/rtl/rdgq_classify.sv =====
module rdgq_classify (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_mid_valid,
    input  rdgq_pkg::t_mid                      i_mid,
    input  logic [rdgq_pkg::CfgW-1:0]           i_fast_rate,
    output logic                                o_valid,
    output rdgq_pkg::t_event                    o_event_code
);

    logic                                       r_valid;
    rdgq_pkg::t_event                           r_code;
    rdgq_pkg::t_event                           n_code;

    logic [rdgq_pkg::TickSumW+19:0]             rate_lhs;
    logic [rdgq_pkg::ProdW-1:0]                 rate_rhs;
    logic                                       fast;

    always_comb begin
        rate_lhs = i_mid.mag * rdgq_pkg::UsPerSecond;
        rate_rhs = i_fast_rate * i_mid.time_us;
        fast     = {{(rdgq_pkg::ProdW - rdgq_pkg::TickSumW - 20){1'b0}}, rate_lhs} > rate_rhs;
        if (i_mid.turn) begin
            if (i_mid.left) begin
                n_code = fast ? rdgq_pkg::EV_LEFT_FAST : rdgq_pkg::EV_LEFT;
            end else begin
                n_code = fast ? rdgq_pkg::EV_RIGHT_FAST : rdgq_pkg::EV_RIGHT;
            end
        end else begin
            n_code = i_mid.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_code <= n_code;
        end
    end

    assign o_valid      = r_valid;
    assign o_event_code = r_code;

endmodule
